FILE: rtl/chm_pkg.sv
// Shared types and constants for the chained hash map.
package chm_pkg;

    localparam int unsigned BucketsDefault = 64;
    localparam int unsigned EntriesDefault = 256;
    localparam int unsigned KeyW = 31;
    localparam int unsigned ValW = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

endpackage

FILE: rtl/chm_entry_mem.sv
// Entry pool memory: key, value and link per slot, one read and one write port.
module chm_entry_mem #(
    parameter int unsigned ENTRIES = chm_pkg::EntriesDefault,
    parameter int unsigned AW      = $clog2(ENTRIES)
) (
    input  logic                    clk,
    input  logic [AW-1:0]           rd_addr,
    output logic [chm_pkg::KeyW-1:0] rd_key,
    output logic [chm_pkg::ValW-1:0] rd_value,
    output logic [AW:0]             rd_link,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [chm_pkg::KeyW-1:0] wr_key,
    input  logic [chm_pkg::ValW-1:0] wr_value,
    input  logic [AW:0]             wr_link
);
    import chm_pkg::*;

    localparam int unsigned EW = KeyW + ValW + AW + 1;

    logic [EW-1:0] mem [ENTRIES];
    logic [EW-1:0] rd_data_reg;

    // Synchronous read and write of whole entries.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_value, wr_link};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_key   = rd_data_reg[EW-1 -: KeyW];
    assign rd_value = rd_data_reg[AW+ValW -: ValW];
    assign rd_link  = rd_data_reg[AW:0];

endmodule

FILE: rtl/chained_hash_map_top.sv
// Top level of the chained hash map: sequencer, heads, free stack and pool.
// From acceptance to result the sequencer runs the hash and head steps, then a read and a check
// per entry visited, plus one more pair when the key is absent. A new-key insert adds an alloc step,
// and a tail-link write when it is appended behind a tail; CMD_NONE goes straight to the result step.
// One item at a time; the next is accepted only after the previous result has entered the output
// register, and waits while that register is still held by the sink.
// Reset: rst_n clears control state and the bucket valid bits; memories are not cleared.
module chained_hash_map_top #(
    parameter int unsigned BUCKETS = chm_pkg::BucketsDefault,
    parameter int unsigned ENTRIES = chm_pkg::EntriesDefault
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic [chm_pkg::KeyW-1:0] lookup_key,
    input  logic signed [chm_pkg::ValW-1:0] new_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [chm_pkg::ValW-1:0] read_value
);
    import chm_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned BW = $clog2(BUCKETS);
    localparam logic [AW:0] NIL = (AW+1)'(ENTRIES);
    // Reciprocal of the bucket count, exact for every key of KeyW bits.
    localparam logic [31:0] RECIP =
        32'(((64'd1 << (KeyW + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_HEAD, S_READ, S_CHECK, S_ALLOC, S_RESULT
    } state_t;

    state_t state_reg;
    logic [1:0]      cmd_reg;
    logic [KeyW-1:0] key_reg;
    logic [ValW-1:0] val_reg;
    logic [AW:0]     cur_reg, prev_reg;
    logic [AW:0]     steps_reg;
    logic [AW:0]     free_depth_reg, fresh_reg;
    logic            res_pend_reg;
    logic [1:0]      res_status_reg;
    logic [ValW-1:0] res_value_reg;
    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic [ValW-1:0] read_value_reg;
    logic [AW:0]     pop_slot_reg;
    logic [KeyW+31:0] prod_reg;
    logic [KeyW-1:0] quot;
    logic [KeyW-1:0] bkt_rem;
    logic [BW-1:0]   bkt_reg;

    // The predecessor's key and value are rewritten with its link, so the
    // previous slot's contents are kept from its read.
    logic [KeyW-1:0] prev_key_reg;
    logic [ValW-1:0] prev_val_reg;

    // Second write for the alloc step: the tail link.
    logic            alloc_tail;
    logic            tail_pend_reg;
    logic [AW:0]     new_slot_reg;

    // Bucket heads with a valid bit each; invalid reads as empty.
    logic [AW:0]        head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;
    logic [AW:0]        head_rd_reg;
    logic               head_we;
    logic [AW:0]        head_wd;
    logic [BW-1:0]      bkt;
    logic [AW:0]        head_val;

    // Free stack memory.
    logic [AW-1:0] free_mem [ENTRIES];
    logic [AW-1:0] free_rd_reg;
    logic          free_we;
    logic [AW-1:0] free_wa;

    // Entry memory port signals.
    logic [AW-1:0]   e_raddr;
    logic [KeyW-1:0] e_rkey;
    logic [ValW-1:0] e_rval;
    logic [AW:0]     e_rlink;
    logic            e_we;
    logic [AW-1:0]   e_waddr;
    logic [KeyW-1:0] e_wkey;
    logic [ValW-1:0] e_wval;
    logic [AW:0]     e_wlink;

    // Bucket index: quotient from the reciprocal product, then the remainder.
    assign quot    = KeyW'(prod_reg >> (KeyW + BW));
    assign bkt_rem = key_reg - KeyW'(quot * KeyW'(BUCKETS));
    assign bkt     = bkt_reg;

    chm_entry_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .clk     (clk),
        .rd_addr (e_raddr),
        .rd_key  (e_rkey),
        .rd_value(e_rval),
        .rd_link (e_rlink),
        .wr_en   (e_we),
        .wr_addr (e_waddr),
        .wr_key  (e_wkey),
        .wr_value(e_wval),
        .wr_link (e_wlink)
    );

    logic hit;
    logic walk_end;
    assign hit      = (e_rkey == key_reg);
    assign walk_end = (cur_reg >= NIL) || (steps_reg >= NIL);

    assign head_val = head_vld_reg[bkt] ? head_rd_reg : NIL;

    // Read the current slot and compute the writes for the check, alloc and tail-link steps.
    always_comb
    begin
        e_raddr = (state_reg == S_READ && steps_reg == '0) ? head_val[AW-1:0]
                                                            : cur_reg[AW-1:0];
        e_we    = 1'b0;
        e_waddr = cur_reg[AW-1:0];
        e_wkey  = e_rkey;
        e_wval  = val_reg;
        e_wlink = e_rlink;
        head_we = 1'b0;
        head_wd = NIL;
        free_we = 1'b0;
        free_wa = free_depth_reg[AW-1:0];
        if (state_reg == S_CHECK && !walk_end && hit)
        begin
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    e_we = 1'b1;
                end
                CMD_REMOVE:
                begin
                    if (prev_reg < NIL)
                    begin
                        e_we    = 1'b1;
                        e_waddr = prev_reg[AW-1:0];
                        e_wkey  = prev_key_reg;
                        e_wval  = prev_val_reg;
                        e_wlink = e_rlink;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wd = e_rlink;
                    end
                    free_we = (free_depth_reg < NIL);
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_ALLOC)
        begin
            if (pop_slot_reg < NIL)
            begin
                e_we    = 1'b1;
                e_waddr = pop_slot_reg[AW-1:0];
                e_wkey  = key_reg;
                e_wval  = val_reg;
                e_wlink = NIL;
            end
        end
        else if (state_reg == S_RESULT && tail_pend_reg)
        begin
            e_we    = 1'b1;
            e_waddr = prev_reg[AW-1:0];
            e_wkey  = prev_key_reg;
            e_wval  = prev_val_reg;
            e_wlink = new_slot_reg;
        end
    end

    assign alloc_tail = (state_reg == S_ALLOC) && (pop_slot_reg < NIL) && (prev_reg < NIL);

    // Memories for heads and free stack.
    always_ff @(posedge clk)
    begin
        if (head_we || (state_reg == S_ALLOC && pop_slot_reg < NIL && prev_reg >= NIL))
        begin
            head_mem[bkt] <= (state_reg == S_ALLOC) ? pop_slot_reg : head_wd;
        end
        head_rd_reg <= head_mem[bkt];
        if (free_we)
        begin
            free_mem[free_wa] <= cur_reg[AW-1:0];
        end
        free_rd_reg <= free_mem[AW'(free_depth_reg - 1'b1)];
    end

    assign in_ready   = (state_reg == S_IDLE) && !res_pend_reg;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

    // Sequencer, result register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_vld_reg   <= '0;
            free_depth_reg <= '0;
            fresh_reg      <= '0;
            res_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tail_pend_reg  <= 1'b0;
            cmd_reg        <= CMD_NONE;
            key_reg        <= '0;
            val_reg        <= '0;
            cur_reg        <= NIL;
            prev_reg       <= NIL;
            steps_reg      <= '0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            status_reg     <= ST_OK;
            read_value_reg <= '0;
            pop_slot_reg   <= NIL;
            prod_reg       <= '0;
            bkt_reg        <= '0;
            prev_key_reg   <= '0;
            prev_val_reg   <= '0;
        end
        else
        begin
            if (res_pend_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg  <= 1'b1;
                status_reg     <= res_status_reg;
                read_value_reg <= res_value_reg;
                res_pend_reg   <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (head_we || (state_reg == S_ALLOC && pop_slot_reg < NIL && prev_reg >= NIL))
            begin
                head_vld_reg[bkt] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg   <= cmd;
                        key_reg   <= lookup_key;
                        val_reg   <= new_value;
                        prod_reg  <= (KeyW+32)'(lookup_key) * (KeyW+32)'(RECIP);
                        prev_reg  <= NIL;
                        steps_reg <= '0;
                        res_value_reg <= '0;
                        state_reg <= (cmd == CMD_NONE) ? S_RESULT : S_HASH;
                        res_status_reg <= ST_OK;
                    end
                end
                S_HASH:
                begin
                    bkt_reg   <= BW'(bkt_rem);
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (steps_reg == '0)
                    begin
                        cur_reg <= head_val;
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (walk_end)
                    begin
                        unique case (cmd_reg)
                            CMD_INSERT:
                            begin
                                if (free_depth_reg > 0)
                                begin
                                    pop_slot_reg   <= (AW+1)'(free_rd_reg);
                                    free_depth_reg <= free_depth_reg - 1'b1;
                                end
                                else if (fresh_reg < NIL)
                                begin
                                    pop_slot_reg <= fresh_reg;
                                    fresh_reg    <= fresh_reg + 1'b1;
                                end
                                else
                                begin
                                    pop_slot_reg <= NIL;
                                end
                                state_reg <= S_ALLOC;
                            end
                            CMD_REMOVE:
                            begin
                                res_status_reg <= ST_NOTFOUND;
                                state_reg      <= S_RESULT;
                            end
                            default:
                            begin
                                res_status_reg <= ST_NOTFOUND;
                                res_value_reg  <= '1;
                                state_reg      <= S_RESULT;
                            end
                        endcase
                    end
                    else if (hit)
                    begin
                        if (cmd_reg == CMD_LOOKUP)
                        begin
                            res_value_reg <= e_rval;
                        end
                        else
                        begin
                            res_value_reg <= '0;
                        end
                        if (cmd_reg == CMD_REMOVE && free_depth_reg < NIL)
                        begin
                            free_depth_reg <= free_depth_reg + 1'b1;
                        end
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        prev_reg     <= cur_reg;
                        prev_key_reg <= e_rkey;
                        prev_val_reg <= e_rval;
                        cur_reg      <= e_rlink;
                        steps_reg    <= steps_reg + 1'b1;
                        state_reg    <= S_READ;
                    end
                end
                S_ALLOC:
                begin
                    if (pop_slot_reg >= NIL)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_RESULT;
                    end
                    else if (prev_reg < NIL)
                    begin
                        tail_pend_reg <= 1'b1;
                        state_reg     <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                    res_value_reg <= '0;
                end
                S_RESULT:
                begin
                    if (!tail_pend_reg)
                    begin
                        res_pend_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        tail_pend_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Slot of the new tail, written into the old tail's link in the next cycle.
    always_ff @(posedge clk)
    begin
        if (alloc_tail)
        begin
            new_slot_reg <= pop_slot_reg;
        end
    end

    // Handshake and bookkeeping checks.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value));
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        res_pend_reg |-> !in_ready);
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_depth_reg <= NIL);
    a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NIL);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != ST_RSVD);

endmodule

FILE: verif/chained_hash_map_checker.sv
// Checker for the chained hash map: watches both channels, predicts and compares results.
module chained_hash_map_checker #(
    parameter int unsigned BUCKETS = chm_pkg::BucketsDefault,
    parameter int unsigned ENTRIES = chm_pkg::EntriesDefault
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [chm_pkg::KeyW-1:0]        lookup_key,
    input  logic signed [chm_pkg::ValW-1:0] new_value,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      status,
    input  logic signed [chm_pkg::ValW-1:0] read_value,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import chm_pkg::*;

    typedef struct packed {
        logic [1:0]       st;
        logic [ValW-1:0]  val;
    } reply_t;

    // Shadow copy of the table.
    int unsigned     head_slot [BUCKETS];
    logic [KeyW-1:0] slot_key  [ENTRIES];
    logic [ValW-1:0] slot_val  [ENTRIES];
    int unsigned     slot_next [ENTRIES];
    int unsigned     freed     [ENTRIES];
    int unsigned     freed_cnt;
    int unsigned     unused_base;
    reply_t          replies_due [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
        freed_cnt = 0;
        unused_base = 0;
        foreach (head_slot[i]) head_slot[i] = ENTRIES;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Apply one request to the shadow table and return the reply it should give.
    function automatic reply_t apply_request(input logic [1:0] op, input logic [KeyW-1:0] k,
                                             input logic [ValW-1:0] v);
        reply_t      r;
        int unsigned b;
        int unsigned cur;
        int unsigned prv;
        int unsigned steps;
        int unsigned slot;
        r = '{st: ST_OK, val: '0};
        if (op == CMD_NONE)
            return r;
        b = k % BUCKETS;
        cur = head_slot[b];
        prv = ENTRIES;
        steps = 0;
        while (cur < ENTRIES && steps < ENTRIES && slot_key[cur] != k)
        begin
            prv = cur;
            cur = slot_next[cur];
            steps++;
        end
        if (steps >= ENTRIES)
            cur = ENTRIES;
        case (op)
            CMD_INSERT:
            begin
                if (cur < ENTRIES)
                    slot_val[cur] = v;
                else
                begin
                    slot = ENTRIES;
                    if (freed_cnt > 0)
                    begin
                        freed_cnt--;
                        slot = freed[freed_cnt];
                    end
                    else if (unused_base < ENTRIES)
                    begin
                        slot = unused_base;
                        unused_base++;
                    end
                    if (slot < ENTRIES)
                    begin
                        slot_key[slot] = k;
                        slot_val[slot] = v;
                        slot_next[slot] = ENTRIES;
                        if (prv < ENTRIES) slot_next[prv] = slot;
                        else head_slot[b] = slot;
                    end
                    else
                        r.st = ST_FULL;
                end
            end
            CMD_REMOVE:
            begin
                if (cur < ENTRIES)
                begin
                    if (prv < ENTRIES) slot_next[prv] = slot_next[cur];
                    else head_slot[b] = slot_next[cur];
                    if (freed_cnt < ENTRIES)
                    begin
                        freed[freed_cnt] = cur;
                        freed_cnt++;
                    end
                end
                else
                    r.st = ST_NOTFOUND;
            end
            default:
            begin
                if (cur < ENTRIES)
                    r.val = slot_val[cur];
                else
                begin
                    r.st = ST_NOTFOUND;
                    r.val = '1;
                end
            end
        endcase
        return r;
    endfunction

    // Sample both channels at each rising edge.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                replies_due.push_back(apply_request(cmd, lookup_key, new_value));
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    report("result item with none expected");
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.st)
                        report($sformatf("status %0d, expected %0d", status, want.st));
                    if (read_value !== want.val)
                        report($sformatf("read_value %0h, expected %0h", read_value,
                                         want.val));
                end
            end
        end
        pending <= replies_due.size();
    end

endmodule

FILE: verif/chained_hash_map_top_tb.sv
// Testbench top for the chained hash map: stimulus, clock, reset and verdict.
module chained_hash_map_top_tb;
    import chm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NB = BucketsDefault;
    localparam int unsigned NE = EntriesDefault;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            cmd = CMD_NONE;
    logic [KeyW-1:0]       lookup_key = '0;
    logic signed [ValW-1:0] new_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic signed [ValW-1:0] read_value;
    int                    fail_count;
    int                    pending;
    logic [KeyW-1:0]       used_keys [$];

    always #5 clk = ~clk;

    chained_hash_map_top #(.BUCKETS(NB), .ENTRIES(NE)) u_dut (.*);

    chained_hash_map_checker #(.BUCKETS(NB), .ENTRIES(NE)) u_chk (.*);

    // Send one item, after a random gap; valid stays up when there is no gap.
    task automatic send_item(input cmd_t op, input logic [KeyW-1:0] k,
                             input logic [ValW-1:0] v);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        lookup_key <= k;
        new_value <= v;
        do @(posedge clk); while (!in_ready);
        if (op == CMD_INSERT) used_keys.push_back(k);
    endtask

    // Key reused about half the time, with colliding buckets and full-range noise.
    function automatic logic [KeyW-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (sel < 8)
            return KeyW'($urandom_range(0, 7) * NB + $urandom_range(0, 3));
        return KeyW'($urandom());
    endfunction

    // Result side stalls at random, with calm stretches.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int n;
        int c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: empty lookups, extreme keys and values, collisions, updates.
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_REMOVE, '1, '0);
        send_item(CMD_INSERT, '0, 32'h8000_0000);
        send_item(CMD_INSERT, '1, 32'h7fff_ffff);
        send_item(CMD_INSERT, KeyW'(NB), 32'hffff_ffff);
        send_item(CMD_INSERT, KeyW'(2 * NB), 32'h1234_5678);
        send_item(CMD_LOOKUP, KeyW'(2 * NB), '0);
        send_item(CMD_INSERT, KeyW'(NB), 32'h0);
        send_item(CMD_LOOKUP, KeyW'(NB), '0);
        send_item(CMD_REMOVE, KeyW'(NB), '0);
        send_item(CMD_LOOKUP, KeyW'(2 * NB), '0);
        send_item(CMD_REMOVE, '0, '0);
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_INSERT, KeyW'(3 * NB), 32'h5555_aaaa);
        send_item(CMD_LOOKUP, '1, '0);
        send_item(CMD_NONE, '1, '1);
        send_item(CMD_REMOVE, '1, '0);
        // Fill the pool past capacity, then drain part of it.
        for (n = 0; n < NE + 4; n++)
            send_item(CMD_INSERT, KeyW'(1000 + n), $urandom());
        send_item(CMD_LOOKUP, KeyW'(1000 + NE + 1), '0);
        for (n = 0; n < 150; n++)
            send_item(CMD_REMOVE, KeyW'(1000 + 2 * n), '0);
        used_keys.delete();
        // Random traffic.
        for (n = 0; n < 1500; n++)
        begin
            c = $urandom_range(0, 19);
            if (c == 0)
                send_item(CMD_NONE, pick_key(), $urandom());
            else if (c < 8)
                send_item(CMD_INSERT, pick_key(), $urandom());
            else if (c < 13)
                send_item(CMD_REMOVE, pick_key(), $urandom());
            else
                send_item(CMD_LOOKUP, pick_key(), $urandom());
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
